### src/csme_pkg.sv
// Shared types and constants for the control-surface MIDI event encoder.
// No dependencies; every other file imports this package.
package csme_pkg;

  // Input opcodes.
  localparam logic [2:0] OP_ENC_DOWN = 3'd0;
  localparam logic [2:0] OP_ENC_UP   = 3'd1;
  localparam logic [2:0] OP_SW_FALL  = 3'd2;
  localparam logic [2:0] OP_SW_RISE  = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  // MIDI status bytes.
  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [7:0] MIDI_CC       = 8'hB0;
  localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;

  localparam logic [6:0] VEL_FULL      = 7'd127;
  localparam logic [6:0] VEL_ZERO      = 7'd0;
  localparam logic [6:0] CC_BASE       = 7'd102;
  localparam logic [6:0] SW_NOTE_BASE  = 7'd10;
  localparam logic [7:0] LOCKOUT_RESET = 8'd10;

  // Tracked switch states.
  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic       last;
  } out_msg_t;

  // Messages caused by one input item, element 0 delivered first.
  typedef struct packed {
    logic [1:0]         count;
    out_msg_t [2:0]     msgs;
  } batch_t;

endpackage

### src/csme_core.sv
// Event state (encoder values, switch states, lockout) and message generation.
// Depends on csme_pkg.
module csme_core import csme_pkg::*; #(
  parameter int NUM_ENCODERS = 5,
  parameter int NUM_SWITCHES = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata,
  input  in_item_t item,
  input  logic     fire,
  output batch_t   batch
);

  localparam int EW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam int SW = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam logic [3:0] NUM_ENC_W = 4'(NUM_ENCODERS);
  localparam logic [3:0] NUM_SW_W  = 4'(NUM_SWITCHES);

  logic [6:0] enc_value [NUM_ENCODERS];
  logic [1:0] sw_state  [NUM_SWITCHES];
  logic       lock_active;
  logic [7:0] lock_remaining;
  logic [7:0] lockout_ticks;

  logic [EW-1:0] eidx;
  logic [SW-1:0] sidx;
  logic       is_enc, is_sw, is_tick, enc_ok, sw_ok, sw_take;
  logic [6:0] v_new, enc_note, sw_note;
  logic [1:0] st_cur, st_new;
  logic [7:0] rem_dec;

  assign eidx    = item.index[EW-1:0];
  assign sidx    = item.index[SW-1:0];
  assign is_enc  = (item.opcode == OP_ENC_DOWN) || (item.opcode == OP_ENC_UP);
  assign is_sw   = (item.opcode == OP_SW_FALL) || (item.opcode == OP_SW_RISE);
  assign is_tick = (item.opcode == OP_TICK);
  assign enc_ok  = is_enc && ({1'b0, item.index} < NUM_ENC_W);
  assign sw_ok   = is_sw && ({1'b0, item.index} < NUM_SW_W) && !lock_active;

  // A 7-bit add or subtract wraps between 0 and 127 by itself.
  assign v_new    = item.opcode[0] ? enc_value[eidx] + 7'd1 : enc_value[eidx] - 7'd1;
  assign enc_note = {3'd0, item.index, item.opcode[0]};
  assign sw_note  = SW_NOTE_BASE + {4'd0, item.index};
  assign st_cur   = sw_state[sidx];
  assign rem_dec  = (lock_remaining != 8'd0) ? lock_remaining - 8'd1 : 8'd0;

  always_comb begin
    sw_take = 1'b0;
    st_new  = st_cur;
    if (item.opcode == OP_SW_FALL) begin
      sw_take = (st_cur == ST_UNKNOWN) || (st_cur == ST_RELEASED);
      st_new  = ST_PRESSED;
    end else begin
      sw_take = (st_cur == ST_PRESSED);
      st_new  = ST_RELEASED;
    end
  end

  always_comb begin
    batch = '0;
    if (enc_ok) begin
      batch.count   = 2'd3;
      batch.msgs[0] = '{MIDI_NOTE_ON, enc_note, VEL_FULL, 1'b0};
      batch.msgs[1] = '{MIDI_CC, CC_BASE + {4'd0, item.index}, v_new, 1'b0};
      batch.msgs[2] = '{MIDI_NOTE_OFF, enc_note, VEL_ZERO, 1'b1};
    end else if (sw_ok && sw_take) begin
      batch.count = 2'd1;
      if (item.opcode == OP_SW_FALL) begin
        batch.msgs[0] = '{MIDI_NOTE_ON, sw_note, VEL_FULL, 1'b1};
      end else begin
        batch.msgs[0] = '{MIDI_NOTE_OFF, sw_note, VEL_ZERO, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENCODERS; i++) enc_value[i] <= 7'd0;
      for (int i = 0; i < NUM_SWITCHES; i++) sw_state[i] <= ST_UNKNOWN;
      lock_active    <= 1'b0;
      lock_remaining <= 8'd0;
      lockout_ticks  <= LOCKOUT_RESET;
    end else begin
      if (cfg_we) begin
        lockout_ticks <= cfg_wdata;
      end
      if (fire) begin
        if (enc_ok) begin
          enc_value[eidx] <= v_new;
        end
        // A rejected edge while unlocked still restarts the counter.
        if (sw_ok) begin
          lock_remaining <= lockout_ticks;
          if (sw_take) begin
            lock_active    <= 1'b1;
            sw_state[sidx] <= st_new;
          end
        end
        if (is_tick) begin
          lock_remaining <= rem_dec;
          if (rem_dec == 8'd0) begin
            lock_active <= 1'b0;
          end
        end
      end
    end
  end

endmodule

### src/csme_outq.sv
// Result queue: holds the messages of one item and hands them out one beat each.
// Depends on csme_pkg.
module csme_outq import csme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  batch_t   batch,
  input  logic     out_stall,
  output logic     out_valid,
  output out_msg_t out_data,
  output logic     pop,
  output logic [1:0] count
);

  out_msg_t [2:0] slots;
  logic [1:0]     cnt;

  assign count     = cnt;
  assign out_valid = (cnt != 2'd0);
  assign out_data  = slots[0];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= batch.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // A load only happens when the queue is empty or its final beat leaves now.
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= batch.msgs;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

### src/control_surface_midi_event_encoder.sv
// Control-surface event encoder: encoder steps and switch edges to MIDI messages.
// The input item is registered, then its results are loaded into the result queue.
// An encoder step yields three beats, a switch edge at most one, ticks and ignored items none;
// the queue sends one beat per cycle unless out_stall is high, and an item with results waits.
// Reset (synchronous): encoder values 0, switches unknown, unlocked, lockout 10.
// Depends on csme_pkg, csme_core and csme_outq.
module control_surface_midi_event_encoder import csme_pkg::*; #(
  parameter int NUM_ENCODERS = 5,
  parameter int NUM_SWITCHES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_msg_t   out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  in_item_t   item;
  logic       item_valid;
  logic       fire;
  logic       pop;
  logic [1:0] q_count;
  batch_t     batch;

  // An item with results may only proceed once the queue can take them all.
  assign fire = item_valid &&
                ((batch.count == 2'd0) || (q_count == 2'd0) ||
                 ((q_count == 2'd1) && pop));
  assign in_stall = item_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  csme_core #(
    .NUM_ENCODERS(NUM_ENCODERS),
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item),
    .fire     (fire),
    .batch    (batch)
  );

  csme_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && (batch.count != 2'd0)),
    .batch    (batch),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .pop      (pop),
    .count    (q_count)
  );

endmodule
